### design/sptq_pkg.sv
// Package for the strict-priority task queue: defaults, function codes,
// the record layout and the request and response beat types.
// Depends on nothing.
package sptq_pkg;

	localparam int LEVELS_DEF = 4;
	localparam int DEPTH_DEF  = 16;

	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_GET = 1'b1;

	typedef struct packed {
		logic [7:0]  task_id;
		logic [15:0] handler_ref;
		logic [31:0] task_param;
	} rec_t;

	typedef struct packed {
		logic        func;
		logic [2:0]  priority_req;
		logic [7:0]  task_id;
		logic [15:0] handler_ref;
		logic [31:0] task_param;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [7:0]  out_task_id;
		logic [15:0] out_handler_ref;
		logic [31:0] out_param;
		logic [1:0]  served_level;
	} rsp_t;

endpackage

### design/sptq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module sptq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/strict_priority_task_queue.sv
// Strict-priority task queue: one ring FIFO of task records per level.
// Depends on sptq_pkg and on sptq_ram for the record store.
//
// Usage. A request beat (req) is taken at a rising edge where start is high
// and busy is low. An add (func = FUNC_ADD) stores its record at the tail of
// the level named by priority_req; it is refused when that level does not
// exist or its ring is full, one slot of each ring always being left empty.
// A get (func = FUNC_GET) removes the oldest record from the lowest-numbered
// non-empty level, level 0 being the most urgent, and fails when every
// level is empty.
//
// Timing. Every request yields exactly one response beat on rsp, marked by
// done for one cycle, in the cycle after the request was taken. busy never
// rises, so a request may be issued in every cycle: one request per clock.
// The figure is set by the single store read, which is issued at the same
// edge as the pointer update and registered inside the RAM.
//
// Reset empties every ring by clearing the read and write pointers; the
// record store itself is not cleared, since only written slots are read.
// The receiver cannot hold a response off: it must take it in its cycle.
module strict_priority_task_queue
	#(
	parameter int LEVELS = sptq_pkg::LEVELS_DEF,
	parameter int DEPTH  = sptq_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sptq_pkg::req_t req,
	output logic           done,
	output sptq_pkg::rsp_t rsp
);
	import sptq_pkg::*;

	localparam int LVL_W = $clog2(LEVELS);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int SLOTS = LEVELS * DEPTH;
	localparam int AW    = $clog2(SLOTS);
	localparam int RW    = $bits(rec_t);

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [AW-1:0]    DEPTH_A  = AW'(DEPTH);

	// Ring pointers, one pair per level.
	logic [PTR_W-1:0] rd_ptr_q [LEVELS];
	logic [PTR_W-1:0] wr_ptr_q [LEVELS];

	// Response register.
	logic       done_q;
	logic       ok_q;
	logic       get_ok_q;
	logic [1:0] served_q;

	logic [LEVELS-1:0] nonempty;
	logic              found;
	logic [2:0]        sel_full;
	logic [LVL_W-1:0]  sel_lvl;
	logic [PTR_W-1:0]  sel_rd;
	logic              in_range;
	logic [LVL_W-1:0]  add_lvl;
	logic [PTR_W-1:0]  add_wr;
	logic [PTR_W-1:0]  add_rd;
	logic              add_full;
	logic              add_ok;
	logic              get_ok;
	logic              accept;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	rec_t              wrec;
	rec_t              rrec;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	// The block takes a request in every cycle.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		nonempty = '0;
		found    = 1'b0;
		sel_full = '0;
		sel_rd   = '0;
		add_wr   = '0;
		add_rd   = '0;
		// A level holds records when its pointers differ.
		for (int i = 0; i < LEVELS; i++) begin
			nonempty[i] = (rd_ptr_q[i] != wr_ptr_q[i]);
		end
		// Scanning downwards leaves the lowest non-empty level selected.
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (nonempty[i]) begin
				found    = 1'b1;
				sel_full = 3'(i);
			end
		end
		sel_lvl  = sel_full[LVL_W-1:0];
		in_range = ({1'b0, req.priority_req} < 4'(LEVELS));
		add_lvl  = req.priority_req[LVL_W-1:0];
		for (int i = 0; i < LEVELS; i++) begin
			if (sel_lvl == LVL_W'(i)) begin
				sel_rd = rd_ptr_q[i];
			end
			if (add_lvl == LVL_W'(i)) begin
				add_wr = wr_ptr_q[i];
				add_rd = rd_ptr_q[i];
			end
		end
		add_full = (ring_next(add_wr) == add_rd);
		add_ok   = accept && (req.func == FUNC_ADD) && in_range && !add_full;
		get_ok   = accept && (req.func == FUNC_GET) && found;
		waddr    = AW'(add_lvl) * DEPTH_A + AW'(add_wr);
		raddr    = AW'(sel_lvl) * DEPTH_A + AW'(sel_rd);
	end

	assign wrec.task_id     = req.task_id;
	assign wrec.handler_ref = req.handler_ref;
	assign wrec.task_param  = req.task_param;

	sptq_ram #(
		.WIDTH (RW),
		.DEPTH (SLOTS)
	) u_store (
		.clk   (clk),
		.we    (add_ok),
		.waddr (waddr),
		.wdata (wrec),
		.re    (get_ok),
		.raddr (raddr),
		.rdata (rrec)
	);

	// Pointer update: an add advances the tail of its level, a get the head
	// of the level that served it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < LEVELS; i++) begin
				if (add_ok && (add_lvl == LVL_W'(i))) begin
					wr_ptr_q[i] <= ring_next(wr_ptr_q[i]);
				end
				if (get_ok && (sel_lvl == LVL_W'(i))) begin
					rd_ptr_q[i] <= ring_next(rd_ptr_q[i]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		ok_q     <= add_ok || get_ok;
		get_ok_q <= get_ok;
		served_q <= get_ok ? sel_full[1:0] : 2'b00;
	end

	// Record fields are shown only for a successful get, zero otherwise.
	assign done                = done_q;
	assign rsp.ok              = ok_q;
	assign rsp.out_task_id     = get_ok_q ? rrec.task_id     : '0;
	assign rsp.out_handler_ref = get_ok_q ? rrec.handler_ref : '0;
	assign rsp.out_param       = get_ok_q ? rrec.task_param  : '0;
	assign rsp.served_level    = served_q;

endmodule

### bench/tb_top.sv
// Self-checking bench for the strict-priority task queue: directed and random request beats,
// with a built-in predictor of the per-level rings checking every response beat.
// Depends on sptq_pkg and strict_priority_task_queue from the design folder.
`timescale 1ns / 100ps

module tb_top;
	import sptq_pkg::*;

	localparam int LEVELS       = LEVELS_DEF;
	localparam int DEPTH        = DEPTH_DEF;
	localparam int PTR_W        = $clog2(DEPTH);
	localparam int RANDOM_BEATS = 1000;
	// The slowest run is roughly 1200 beats, each followed by a short random gap from pick_gap.
	// Even with the longest gaps the run stays far below this limit, which leaves ample margin.
	localparam int CYCLE_LIMIT  = 200000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;

	strict_priority_task_queue #(
		.LEVELS(LEVELS),
		.DEPTH (DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The predictor's own copy of the queue. It holds one head and one tail pointer per level,
	// together with the record store. It is updated at the edge that accepts each request beat.
	logic [PTR_W-1:0] level_head [LEVELS];
	logic [PTR_W-1:0] level_tail [LEVELS];
	rec_t             level_slots [LEVELS*DEPTH];

	rsp_t pending_rsp_q [$];
	rsp_t oldest_rsp;
	int   errors      = 0;
	int   cycle_count = 0;
	bit   quiet_phase = 1'b0;
	bit   start_held  = 1'b0;

	function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Applies one request to the predicted queue and returns the response beat it should give.
	// Refused adds, and gets when every level is empty, return an all-zero response.
	function automatic rsp_t serve_request(input req_t beat);
		rsp_t             result;
		rec_t             entry;
		int               lvl;
		logic [PTR_W-1:0] nxt;
		result = '0;
		if (beat.func == FUNC_ADD) begin
			lvl = int'(beat.priority_req);
			if (lvl < LEVELS) begin
				nxt = ring_advance(level_tail[lvl]);
				// One slot is always left empty, so a level is full when the tail would meet the head.
				if (nxt != level_head[lvl]) begin
					entry.task_id     = beat.task_id;
					entry.handler_ref = beat.handler_ref;
					entry.task_param  = beat.task_param;
					level_slots[lvl*DEPTH + int'(level_tail[lvl])] = entry;
					level_tail[lvl] = nxt;
					result.ok = 1'b1;
				end
			end
		end else begin
			for (int i = 0; i < LEVELS; i++) begin
				if (level_head[i] != level_tail[i]) begin
					entry = level_slots[i*DEPTH + int'(level_head[i])];
					result.ok              = 1'b1;
					result.out_task_id     = entry.task_id;
					result.out_handler_ref = entry.handler_ref;
					result.out_param       = entry.task_param;
					result.served_level    = 2'(i);
					level_head[i] = ring_advance(level_head[i]);
					return result;
				end
			end
		end
		return result;
	endfunction

	// Most gaps are short, and a few are long. A quiet phase sends beats back to back.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic req_t make_add(input int lvl);
		req_t beat;
		beat.func         = FUNC_ADD;
		beat.priority_req = 3'(lvl);
		beat.task_id      = 8'($urandom_range(0, 255));
		beat.handler_ref  = 16'($urandom_range(0, 65535));
		beat.task_param   = $urandom();
		case ($urandom_range(0, 9))
			0: begin
				beat.task_id     = '0;
				beat.handler_ref = '0;
				beat.task_param  = '0;
			end
			1: begin
				beat.task_id     = '1;
				beat.handler_ref = '1;
				beat.task_param  = '1;
			end
			default: ;
		endcase
		return beat;
	endfunction

	// A get ignores its payload, so the payload is filled with random noise.
	function automatic req_t make_get();
		req_t beat;
		beat              = make_add($urandom_range(0, 7));
		beat.func         = FUNC_GET;
		return beat;
	endfunction

	// Drives one request beat and holds it until it is taken. The expectation is recorded at the
	// accepting edge. start is lowered only when a gap follows, so back-to-back beats keep it high.
	task automatic send_beat(input req_t beat, input int gap);
		req        <= beat;
		start      <= 1'b1;
		start_held = 1'b1;
		do
			@(posedge clk);
		while (busy);
		pending_rsp_q.push_back(serve_request(beat));
		if (gap > 0) begin
			start      <= 1'b0;
			start_held = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Response beats cannot be held off, so every cycle with done high is a beat to check.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp_q.size() == 0) begin
				$display("%0t: unexpected response beat: expected none, actual %h", $time, rsp);
				errors++;
			end else begin
				oldest_rsp = pending_rsp_q.pop_front();
				check_field("ok", 64'(oldest_rsp.ok), 64'(rsp.ok));
				check_field("out_task_id", 64'(oldest_rsp.out_task_id),
					64'(rsp.out_task_id));
				check_field("out_handler_ref", 64'(oldest_rsp.out_handler_ref),
					64'(rsp.out_handler_ref));
				check_field("out_param", 64'(oldest_rsp.out_param), 64'(rsp.out_param));
				check_field("served_level", 64'(oldest_rsp.served_level),
					64'(rsp.served_level));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// The directed part covers gets on an empty queue, field extremes, levels out of range, and
	// strict priority order with FIFO order within a level.
	task automatic test_directed();
		req_t beat;
		send_beat(make_get(), pick_gap());
		beat = make_add(0);
		beat.task_id = '1; beat.handler_ref = '1; beat.task_param = '1;
		send_beat(beat, pick_gap());
		beat = make_add(0);
		beat.task_id = '0; beat.handler_ref = '0; beat.task_param = '0;
		send_beat(beat, pick_gap());
		beat = make_add(LEVELS - 1);
		beat.task_id = 8'hA5; beat.handler_ref = 16'h5AA5; beat.task_param = 32'hDEADBEEF;
		send_beat(beat, pick_gap());
		// Levels that do not exist are refused, however full the payload is.
		for (int lvl = LEVELS; lvl < 8; lvl++) begin
			beat = make_add(lvl);
			beat.task_id = '1; beat.handler_ref = '1; beat.task_param = '1;
			send_beat(beat, pick_gap());
		end
		send_beat(make_add(2), pick_gap());
		send_beat(make_add(1), pick_gap());
		repeat (5) send_beat(make_get(), pick_gap());
		send_beat(make_get(), pick_gap());
	endtask

	// Every level is filled until it refuses an add, and then the whole queue is drained.
	// The drain ends with one get on an empty queue.
	task automatic test_full_levels();
		quiet_phase = 1'($urandom_range(0, 1));
		for (int lvl = LEVELS - 1; lvl >= 0; lvl--)
			repeat (DEPTH) send_beat(make_add(lvl), pick_gap());
		repeat (LEVELS*(DEPTH - 1) + 1) send_beat(make_get(), pick_gap());
		quiet_phase = 1'b0;
	endtask

	// Random traffic runs in rounds. A round favours adds, or favours gets, or mixes the two evenly.
	// Its adds mostly go to one level, so that level fills and empties repeatedly. A minority of
	// adds names a level that does not exist.
	task automatic test_random_traffic();
		int sent;
		int add_pct;
		int focus;
		int round_len;
		int lvl;
		int r;
		sent = 0;
		while (sent < RANDOM_BEATS) begin
			case ($urandom_range(0, 2))
				0:       add_pct = 85;
				1:       add_pct = 15;
				default: add_pct = 50;
			endcase
			focus       = $urandom_range(0, LEVELS - 1);
			round_len   = $urandom_range(10, 60);
			quiet_phase = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < round_len; k++) begin
				if ($urandom_range(0, 99) < add_pct) begin
					r = $urandom_range(0, 99);
					if (r < 65)
						lvl = focus;
					else if (r < 92)
						lvl = $urandom_range(0, LEVELS - 1);
					else
						lvl = $urandom_range(LEVELS, 7);
					send_beat(make_add(lvl), pick_gap());
				end else begin
					send_beat(make_get(), pick_gap());
				end
				sent++;
			end
		end
		quiet_phase = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		for (int i = 0; i < LEVELS; i++) begin
			level_head[i] = '0;
			level_tail[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_levels();
		test_random_traffic();

		if (start_held)
			start <= 1'b0;
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		// The response comes in the cycle after its request, so the extra wait below exposes any stray beat.
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
